FILE: design/rrp_pkg.sv
// Shared types and constants for the rectangle raster painter.
// No dependencies.
package rrp_pkg;

  localparam int FIELD_W = 20;
  localparam int CFG_W   = 9;
  localparam int RECT_W  = 28;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BACKGROUND   = 2'd2;

  localparam logic [CFG_W-1:0] FRAME_DIM_RESET = 9'd256;
  localparam logic [7:0]       BACKGROUND_RESET = 8'd32;

  typedef struct packed {
    logic [1:0]                operation;
    logic                      outline_only;
    logic signed [FIELD_W-1:0] rect_left;
    logic signed [FIELD_W-1:0] rect_top;
    logic signed [FIELD_W-1:0] rect_width;
    logic signed [FIELD_W-1:0] rect_height;
    logic [7:0]                paint_char;
    logic [7:0]                pixel_col;
    logic [7:0]                pixel_row;
  } rrp_cmd_t;

  typedef struct packed {
    logic       status;
    logic [7:0] pixel_char;
  } rrp_rsp_t;

  // Rectangle bounds in pixel fixed point; *_in are the inner border limits.
  typedef struct packed {
    logic                     outline;
    logic signed [RECT_W-1:0] left;
    logic signed [RECT_W-1:0] right;
    logic signed [RECT_W-1:0] left_in;
    logic signed [RECT_W-1:0] right_in;
    logic signed [RECT_W-1:0] top;
    logic signed [RECT_W-1:0] bottom;
    logic signed [RECT_W-1:0] top_in;
    logic signed [RECT_W-1:0] bottom_in;
  } rrp_rect_t;

endpackage

FILE: design/rrp_cover.sv
// Pixel coverage test for one pixel against the latched rectangle bounds.
// Depends on rrp_pkg.
module rrp_cover #(
  parameter int FRAC_BITS = 8,
  parameter int IDX_W     = 8
) (
  input  rrp_pkg::rrp_rect_t rect,
  input  logic [IDX_W-1:0]   x,
  input  logic [IDX_W-1:0]   y,
  output logic               hit
);
  import rrp_pkg::*;

  logic signed [RECT_W-1:0] px;
  logic signed [RECT_W-1:0] py;
  logic                     in_x;
  logic                     in_y;
  logic                     border;

  assign px = RECT_W'(x) << FRAC_BITS;
  assign py = RECT_W'(y) << FRAC_BITS;

  assign in_x   = (px >= rect.left) && (px <= rect.right);
  assign in_y   = (py >= rect.top) && (py <= rect.bottom);
  assign border = (px < rect.left_in) || (px > rect.right_in) ||
                  (py < rect.top_in) || (py > rect.bottom_in);
  assign hit    = in_x && in_y && (!rect.outline || border);

endmodule

FILE: design/rectangle_raster_painter_unit.sv
// Channel  Dir  Payload     Transfer
// cmd      in   rrp_cmd_t   cmd_valid & !cmd_stall
// rsp      out  rrp_rsp_t   rsp_valid & !rsp_stall
// cfg      in   cfg_data    cfg_write (no handshake)
// Clear and draw sweep the frame: the sweep writes one pixel per
// cycle through the single frame memory write port. A rejected draw, or any
// clear or draw on an empty frame, skips the sweep. A read goes through ST_READ.
// Clear and draw post their result at acceptance, before the sweep ends.
// Reset does not clear the frame; pixels read before a clear are undefined.
// A result is registered; the input stalls while a result is held by rsp_stall.
// Depends on rrp_pkg and rrp_cover.
module rectangle_raster_painter_unit #(
  parameter int MAX_DIM   = 256,
  parameter int FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_stall,
  input  rrp_pkg::rrp_cmd_t       cmd,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output rrp_pkg::rrp_rsp_t       rsp,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [rrp_pkg::CFG_W-1:0] cfg_data
);
  import rrp_pkg::*;

  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW     = $clog2(MAX_DIM + 1);
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [RECT_W-1:0] ONE = RECT_W'(2 ** FRAC_BITS);

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_READ} state_t;

  state_t            state;
  logic [CFG_W-1:0]  frame_width;
  logic [CFG_W-1:0]  frame_height;
  logic [7:0]        background_char;
  logic [DW-1:0]     fw_used;
  logic [DW-1:0]     fh_used;
  logic [DW-1:0]     fw_l;
  logic [DW-1:0]     fh_l;
  logic [IDX_W-1:0]  x;
  logic [IDX_W-1:0]  y;
  logic [ADDR_W-1:0] row_base;
  logic              sweep_all;
  logic [7:0]        sweep_char;
  rrp_rect_t         rect;
  rrp_rect_t         rect_next;
  logic              rejected;
  logic              rd_in_range;
  logic              accept;
  logic              rsp_load;
  logic              last_x;
  logic              last_y;
  logic              hit;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  logic [7:0]        frame_mem [DEPTH];

  assign cmd_stall = rst || (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = cmd_valid && !cmd_stall;
  assign rsp_load  = (accept && (cmd.operation != OP_READ)) || (state == ST_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= FRAME_DIM_RESET;
      frame_height    <= FRAME_DIM_RESET;
      background_char <= BACKGROUND_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        CFG_BACKGROUND:   background_char <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign fw_used = (16'(frame_width) > 16'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(frame_width);
  assign fh_used = (16'(frame_height) > 16'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(frame_height);

  assign rejected = (cmd.rect_width <= 0) || (cmd.rect_height <= 0);

  always_comb begin
    logic signed [RECT_W-1:0] l_ext;
    logic signed [RECT_W-1:0] t_ext;
    logic signed [RECT_W-1:0] r_ext;
    logic signed [RECT_W-1:0] b_ext;
    l_ext = RECT_W'(cmd.rect_left);
    t_ext = RECT_W'(cmd.rect_top);
    r_ext = l_ext + RECT_W'(cmd.rect_width);
    b_ext = t_ext + RECT_W'(cmd.rect_height);
    rect_next.outline   = cmd.outline_only;
    rect_next.left      = l_ext;
    rect_next.right     = r_ext;
    rect_next.left_in   = l_ext + ONE;
    rect_next.right_in  = r_ext - ONE;
    rect_next.top       = t_ext;
    rect_next.bottom    = b_ext;
    rect_next.top_in    = t_ext + ONE;
    rect_next.bottom_in = b_ext - ONE;
  end

  rrp_cover #(
    .FRAC_BITS (FRAC_BITS),
    .IDX_W     (IDX_W)
  ) u_cover (
    .rect (rect),
    .x    (x),
    .y    (y),
    .hit  (hit)
  );

  assign last_x    = (DW'(x) == fw_l - DW'(1));
  assign last_y    = (DW'(y) == fh_l - DW'(1));
  assign mem_we    = (state == ST_SWEEP) && (sweep_all || hit);
  assign mem_waddr = row_base + ADDR_W'(x);
  assign mem_re    = accept && (cmd.operation == OP_READ);
  assign mem_raddr = ADDR_W'(cmd.pixel_row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.pixel_col);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= sweep_char;
    end
    if (mem_re) begin
      mem_rdata <= frame_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            x        <= '0;
            y        <= '0;
            row_base <= '0;
            fw_l     <= fw_used;
            fh_l     <= fh_used;
            case (cmd.operation)
              OP_CLEAR: begin
                rsp        <= '0;
                sweep_all  <= 1'b1;
                sweep_char <= background_char;
                if ((fw_used != '0) && (fh_used != '0)) begin
                  state <= ST_SWEEP;
                end
              end
              OP_DRAW: begin
                rsp.status     <= rejected;
                rsp.pixel_char <= '0;
                rect           <= rect_next;
                sweep_all      <= 1'b0;
                sweep_char     <= cmd.paint_char;
                if (!rejected && (fw_used != '0) && (fh_used != '0)) begin
                  state <= ST_SWEEP;
                end
              end
              OP_READ: begin
                rd_in_range <= (16'(cmd.pixel_col) < 16'(fw_used)) &&
                               (16'(cmd.pixel_row) < 16'(fh_used));
                state       <= ST_READ;
              end
              default: begin
                rsp <= '0;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          if (last_x) begin
            x        <= '0;
            row_base <= row_base + ADDR_W'(MAX_DIM);
            if (last_y) begin
              state <= ST_IDLE;
            end else begin
              y <= y + 1'b1;
            end
          end else begin
            x <= x + 1'b1;
          end
        end
        ST_READ: begin
          rsp.status     <= 1'b0;
          rsp.pixel_char <= rd_in_range ? mem_rdata : 8'd0;
          state          <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/rrp_checker.sv
// Port-level checks for rectangle_raster_painter_unit, bound to the top level.
// Depends on rrp_pkg.
module rrp_checker (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input rrp_pkg::rrp_rsp_t rsp
);
  import rrp_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_reject_no_char: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> rsp.pixel_char == 8'd0)
    else $error("rejected draw carries a character");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> rsp_valid || cmd_stall)
    else $error("accepted transaction left no trace");

endmodule

bind rectangle_raster_painter_unit rrp_checker u_rrp_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
